// ===== sv/jsync_pkg.sv =====
package jsync_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PORTS_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int PORT_W      = 5;
  localparam int VALUE_W     = 32;
  localparam int CNT_RAW_W   = 6;
  localparam int MASK_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PORT_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REARM       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_WAIT  = 3'd3;

  // Reset values of the registers
  localparam logic [CNT_RAW_W-1:0] PORT_COUNT_RST = 6'd2;
  localparam logic [MASK_W-1:0]    MASK_RST       = 32'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store;     // write the input beat, update wait bits
    logic load_cnt;  // start a burst at the highest port in use
    logic rd_en;     // read the value memory
    logic dec;       // read the next lower port and step the counter down
    logic out_load;  // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic port_ok;   // input port is in use
    logic fire;      // this beat completes the join
    logic cnt_zero;  // counter sits at port 0
    logic out_free;  // output register can take a beat
  } dp_sts_t;

endpackage

// ===== sv/jsync_ctrl.sv =====
module jsync_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  jsync_pkg::dp_sts_t sts_i,
  output jsync_pkg::dp_cmd_t cmd_o
);
  import jsync_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i && sts_i.port_ok && sts_i.fire) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.cnt_zero) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i && sts_i.port_ok) begin
          cmd_o.store    = 1'b1;
          cmd_o.load_cnt = sts_i.fire;
        end
      end
      ST_FETCH: cmd_o.rd_en = 1'b1;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!sts_i.cnt_zero) begin
            cmd_o.rd_en = 1'b1;
            cmd_o.dec   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/jsync_dp.sv =====
module jsync_dp #(
  parameter int MAX_PORTS  = jsync_pkg::MAX_PORTS_DEF,
  parameter int DATA_WIDTH = jsync_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jsync_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [jsync_pkg::MASK_W-1:0]    cfg_data_i,
  input  logic [jsync_pkg::PORT_W-1:0]    in_port_i,
  input  logic [jsync_pkg::VALUE_W-1:0]   in_value_i,
  input  jsync_pkg::dp_cmd_t              cmd_i,
  output jsync_pkg::dp_sts_t              sts_o,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic [jsync_pkg::PORT_W-1:0]    out_port_o,
  output logic [jsync_pkg::VALUE_W-1:0]   out_value_o,
  output logic                           out_last_o
);
  import jsync_pkg::*;

  localparam int IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int CNT_W = $clog2(MAX_PORTS + 1);
  localparam int SW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [CNT_W-1:0]  n_q, n_d;
  logic [MASK_W-1:0] trig_q, rearm_q, pend_q;
  logic [MASK_W-1:0] used, bit_mask, remain;
  logic [IDX_W-1:0]  cnt_q, rd_addr, wr_addr;
  logic [SW-1:0]     mem_q [MAX_PORTS];
  logic [MAX_PORTS-1:0] valid_q;
  logic [SW-1:0]     rdata_q;
  logic              m_valid_q;
  logic [PORT_W-1:0] port_q;
  logic [SW-1:0]     value_q;
  logic              last_q;
  logic              out_free;

  // Port count is clamped to the legal range when written
  always_comb begin
    if (cfg_data_i[CNT_RAW_W-1:0] < PORT_COUNT_RST) begin
      n_d = CNT_W'(PORT_COUNT_RST);
    end else if (cfg_data_i[CNT_RAW_W-1:0] > CNT_RAW_W'(MAX_PORTS)) begin
      n_d = CNT_W'(MAX_PORTS);
    end else begin
      n_d = cfg_data_i[CNT_W-1:0];
    end
  end

  // Mask of ports in use
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      used[i] = (CNT_RAW_W'(i) < CNT_RAW_W'(n_q));
    end
  end

  // Join test for the incoming beat
  assign bit_mask       = MASK_W'(1) << in_port_i;
  assign remain         = pend_q & ~bit_mask & used;
  assign wr_addr        = in_port_i[IDX_W-1:0];
  assign sts_o.port_ok  = (CNT_RAW_W'(in_port_i) < CNT_RAW_W'(n_q));
  assign sts_o.fire     = (remain == '0) && trig_q[in_port_i];
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign out_free       = !m_valid_q || m_ready_i;
  assign sts_o.out_free = out_free;

  // Configuration registers and wait bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= CNT_W'(PORT_COUNT_RST);
      trig_q  <= MASK_RST;
      rearm_q <= MASK_RST;
      pend_q  <= MASK_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PORT_COUNT: n_q     <= n_d;
          REG_TRIGGER:    trig_q  <= cfg_data_i;
          REG_REARM:      rearm_q <= cfg_data_i;
          REG_START_WAIT: pend_q  <= cfg_data_i;
          default: ;
        endcase
      end else if (cmd_i.store) begin
        pend_q <= sts_o.fire ? rearm_q : (pend_q & ~bit_mask);
      end
    end
  end

  // Burst counter, highest port in use down to port 0
  assign rd_addr = cmd_i.dec ? (cnt_q - IDX_W'(1)) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_cnt) begin
      cnt_q <= IDX_W'(n_q - CNT_W'(1));
    end else if (cmd_i.dec) begin
      cnt_q <= cnt_q - IDX_W'(1);
    end
  end

  // Value memory; entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem_q[wr_addr] <= in_value_i[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.store) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      port_q  <= PORT_W'(cnt_q);
      value_q <= rdata_q;
      last_q  <= (cnt_q == '0);
    end
  end

  assign m_valid_o   = m_valid_q;
  assign out_port_o  = port_q;
  assign out_value_o = VALUE_W'(value_q);
  assign out_last_o  = last_q;

endmodule

// ===== sv/input_join_synchronizer_top.sv =====
// Join over up to MAX_PORTS input ports. Each input beat names a port and a
// value; the value is stored in that port's slot and the port's wait bit is
// cleared. When no wait bit of a port in use remains and the arriving port is
// in the trigger mask, the wait bits reload from the rearm mask and a burst
// of one beat per port in use follows, highest port first, tlast on port 0.
// Beats for ports at or beyond the port count are dropped. Each beat is
// taken in the idle state; a firing beat leads through a fetch state into
// the burst, since the single read port of the value memory is registered
// and yields one stored value per cycle while the output is not stalled. No
// input is taken during a burst. The memory needs no clearing pass: per-entry
// valid bits make unwritten slots read as zero. Configuration writes are
// always ready and must only occur while the block is idle; writing
// start_wait_mask reloads the wait bits at once.
module input_join_synchronizer_top #(
  parameter int MAX_PORTS  = jsync_pkg::MAX_PORTS_DEF,
  parameter int DATA_WIDTH = jsync_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jsync_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jsync_pkg::MASK_W-1:0]      cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [jsync_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // port[4:0], value[36:5]
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [jsync_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_port[4:0], out_value[36:5]
  output logic                             m_axis_tlast
);
  import jsync_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [PORT_W-1:0]  out_port;
  logic [VALUE_W-1:0] out_value;

  assign cfg_ready_o = 1'b1;

  jsync_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  jsync_dp #(
    .MAX_PORTS  (MAX_PORTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_port_i   (s_axis_tdata[PORT_W-1:0]),
    .in_value_i  (s_axis_tdata[PORT_W +: VALUE_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .out_port_o  (out_port),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - PORT_W - VALUE_W)'(0), out_value, out_port};

  // The final beat of a burst always carries port 0
  a_last_port0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[PORT_W-1:0] == '0)
    else $error("burst end not on port 0");

  // No input beat is taken while a burst is still being sent
  a_no_input_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted during burst");

  // Every output beat carries a port within the range of the memory
  a_burst_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[PORT_W-1:0] < PORT_W'(MAX_PORTS - 1) ||
                      m_axis_tdata[PORT_W-1:0] == PORT_W'(MAX_PORTS - 1))
    else $error("output port out of range");

endmodule

// ===== tb/tb_input_join_synchronizer_top.sv =====
module tb_input_join_synchronizer_top;
  import jsync_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYC   = 8;
  localparam int HOLD_CYC     = 300;
  localparam int TAIL_CYC     = 40;
  localparam int NUM_SLOTS    = MAX_PORTS_DEF;
  localparam int REPORT_MAX   = 10;
  localparam int SEG_ITEMS    = 18;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  // One emitted beat of a burst
  typedef struct packed {
    logic [PORT_W-1:0]  port;
    logic [VALUE_W-1:0] value;
    logic               last;
  } join_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [MASK_W-1:0]      cfg_data_i  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // port[4:0], value[36:5]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // out_port[4:0], out_value[36:5]
  logic                   m_axis_tlast;

  input_join_synchronizer_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the join state
  logic [CNT_RAW_W-1:0] cnt_raw;
  logic [MASK_W-1:0]    trig_bits;
  logic [MASK_W-1:0]    rearm_bits;
  logic [MASK_W-1:0]    wait_bits;
  logic [VALUE_W-1:0]   slot_val [NUM_SLOTS];

  join_beat_t burst_q [$];
  int         mismatch_cnt  = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       hold_req      = 1'b0;

  function automatic int ports_active();
    if (cnt_raw < 2) return 2;
    if (cnt_raw > NUM_SLOTS) return NUM_SLOTS;
    return int'(cnt_raw);
  endfunction

  function automatic logic [MASK_W-1:0] active_mask();
    int n;
    n = ports_active();
    return (n >= MASK_W) ? '1 : ((MASK_W'(1) << n) - 1);
  endfunction

  function automatic void reset_shadow();
    cnt_raw    = PORT_COUNT_RST;
    trig_bits  = MASK_RST;
    rearm_bits = MASK_RST;
    wait_bits  = MASK_RST;
    for (int i = 0; i < NUM_SLOTS; i++) slot_val[i] = '0;
  endfunction

  function automatic void shadow_reg_write(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
    case (idx)
      REG_PORT_COUNT: cnt_raw = data[CNT_RAW_W-1:0];
      REG_TRIGGER:    trig_bits = data;
      REG_REARM:      rearm_bits = data;
      REG_START_WAIT: wait_bits = data;
      default: ;
    endcase
  endfunction

  // Store the value, clear the wait bit, queue a burst when the join completes
  function automatic void predict_arrival(logic [PORT_W-1:0] port, logic [VALUE_W-1:0] value);
    int         n;
    join_beat_t b;
    n = ports_active();
    if (int'(port) >= n) return;
    slot_val[port]  = value;
    wait_bits[port] = 1'b0;
    if ((wait_bits & active_mask()) == '0 && trig_bits[port]) begin
      wait_bits = rearm_bits;
      for (int i = n - 1; i >= 0; i--) begin
        b.port  = PORT_W'(i);
        b.value = slot_val[i];
        b.last  = (i == 0);
        burst_q.push_back(b);
      end
    end
  endfunction

  // Sender: optional gap, then hold the beat until it is taken
  task automatic send_arrival(logic [PORT_W-1:0] port, logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, value, port};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_arrival(port, value);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_reg_write(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering beats and let every pending burst drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (burst_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_all(logic [MASK_W-1:0] cnt, logic [MASK_W-1:0] trig,
                           logic [MASK_W-1:0] rearm, logic [MASK_W-1:0] start);
    write_reg(REG_PORT_COUNT, cnt);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_REARM, rearm);
    write_reg(REG_START_WAIT, start);
  endtask

  // Receiver: check each beat against the oldest expectation, then pick tready
  always @(posedge clk_i) begin
    join_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (burst_q.size() == 0) begin
        if (mismatch_cnt < REPORT_MAX)
          $display("ERROR: unexpected beat port=%0d value=%h last=%b",
                   m_axis_tdata[4:0], m_axis_tdata[36:5], m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = burst_q.pop_front();
        if (m_axis_tdata[4:0] !== want.port || m_axis_tdata[36:5] !== want.value ||
            m_axis_tlast !== want.last) begin
          if (mismatch_cnt < REPORT_MAX)
            $display({"ERROR: beat mismatch exp port=%0d value=%h last=%b,",
                      " got port=%0d value=%h last=%b"},
                     want.port, want.value, want.last,
                     m_axis_tdata[4:0], m_axis_tdata[36:5], m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
    m_axis_tready <= !hold_req && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off, counted here
  always begin
    wait (hold_req);
    repeat (HOLD_CYC) @(posedge clk_i);
    hold_req <= 1'b0;
    @(posedge clk_i);
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Reset defaults: two ports, both awaited, both trigger
  task automatic test_reset_defaults();
    send_arrival(5'd0, 32'h0000_0000);
    send_arrival(5'd1, 32'hFFFF_FFFF);
    send_arrival(5'd1, 32'h1234_5678);
    send_arrival(5'd2, 32'hDEAD_BEEF);  // not in use
    send_arrival(5'd31, 32'hFFFF_FFFF); // not in use
    send_arrival(5'd0, 32'hFFFF_FFFF);
    settle();
  endtask

  // Start-wait write reloads wait bits; wait bits of unused ports are ignored
  task automatic test_start_wait();
    write_reg(REG_START_WAIT, 32'h0000_0002);
    send_arrival(5'd0, 32'h8000_0001);
    settle();
    write_reg(REG_START_WAIT, 32'h0000_0000);
    send_arrival(5'd0, 32'h0F0F_0F0F);
    settle();
    write_all(32'd4, 32'h0000_0008, 32'h0000_000F, 32'hFFFF_FFF0);
    send_arrival(5'd3, 32'hA5A5_A5A5);
    settle();
  endtask

  // Port count below 2 and above the maximum are clamped
  task automatic test_port_count_clamp();
    write_all(32'hFFFF_FFC1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_arrival(5'd2, 32'h1111_1111);
    send_arrival(5'd1, 32'h2222_2222);
    settle();
    write_reg(REG_PORT_COUNT, 32'd63);
    send_arrival(5'd31, 32'hFFFF_FFFF);
    settle();
    write_reg(REG_PORT_COUNT, 32'd0);
    send_arrival(5'd31, 32'h3333_3333);
    send_arrival(5'd0, 32'h4444_4444);
    settle();
    write_reg(REG_PORT_COUNT, 32'd33);
    send_arrival(5'd16, 32'h5555_5555);
    settle();
  endtask

  // Empty trigger mask never fires; an unknown register index is dropped
  task automatic test_trigger_off();
    write_all(32'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_arrival(5'd0, 32'h0000_0001);
    send_arrival(5'd1, 32'h0000_0002);
    send_arrival(5'd2, 32'h0000_0004);
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_TRIGGER, 32'hFFFF_FFFF);
    send_arrival(5'd2, 32'h7FFF_FFFF);
    settle();
  endtask

  // Receiver stalls for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(32'd4, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    hold_req <= 1'b1;
    for (int i = 0; i < 16; i++)
      send_arrival(PORT_W'($urandom_range(3)), $urandom);
    settle();
  endtask

  task automatic random_config();
    int                r;
    logic [MASK_W-1:0] cnt;
    r = $urandom_range(99);
    if (r < 70)      cnt = $urandom_range(6, 2);
    else if (r < 80) cnt = 32;
    else if (r < 85) cnt = $urandom_range(63, 33);
    else if (r < 90) cnt = $urandom_range(1, 0);
    else             cnt = $urandom_range(31, 7);
    cnt = ($urandom & ~32'h3F) | cnt;
    r = $urandom_range(99);
    write_all(cnt, (r < 50) ? $urandom : (r < 75) ? 32'hFFFF_FFFF : (32'd1 << $urandom_range(31)),
              $urandom, $urandom);
  endtask

  // Mostly complete joins in random order, some stray and dropped beats
  task automatic random_segment(int n_items);
    int                sent;
    int                n;
    int                cnt;
    int                j;
    int                tmp;
    int                order [NUM_SLOTS];
    logic [MASK_W-1:0] need;
    logic [PORT_W-1:0] p;
    sent = 0;
    while (sent < n_items) begin
      n = ports_active();
      if ($urandom_range(99) < 70) begin
        need = wait_bits & active_mask();
        cnt  = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (need[i]) begin
            order[cnt] = i;
            cnt++;
          end
        for (int i = cnt - 1; i > 0; i--) begin
          j        = $urandom_range(i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < cnt; i++) send_arrival(PORT_W'(order[i]), $urandom);
        sent += cnt;
        need = trig_bits & active_mask();
        p    = PORT_W'($urandom_range(n - 1));
        if (need != '0)
          while (!need[p]) p = PORT_W'($urandom_range(n - 1));
        send_arrival(p, $urandom);
        sent++;
      end else begin
        p = ($urandom_range(9) == 0) ? PORT_W'($urandom) : PORT_W'($urandom_range(n - 1));
        send_arrival(p, $urandom);
        if (int'(p) < n) sent++;
      end
    end
    settle();
  endtask

  task automatic test_random_phase(int snd_pct, int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int k = 0; k < 3; k++) begin
      random_config();
      random_segment(SEG_ITEMS);
    end
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_start_wait();
    test_port_count_clamp();
    test_trigger_off();
    test_backpressure();
    test_random_phase(35, 53);
    test_random_phase(53, 35);
    test_random_phase(0, 0);

    repeat (TAIL_CYC) @(posedge clk_i);
    if (burst_q.size() != 0) begin
      $display("ERROR: %0d expected beats never arrived", burst_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/jsync_pkg.sv
sv/jsync_ctrl.sv
sv/jsync_dp.sv
sv/input_join_synchronizer_top.sv
tb/tb_input_join_synchronizer_top.sv
